// File: design/proofing_heater_fan_controller_assert.svh
// Assertion macros shared by the heater and fan controller RTL.
`ifndef PROOFING_HEATER_FAN_CONTROLLER_ASSERT_SVH
`define PROOFING_HEATER_FAN_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PHFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("phfc assertion failed");

// Next-cycle implication, checked out of reset.
`define PHFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("phfc assertion failed");

`endif

// File: design/phfc_pkg.sv
// Package: constants, status codes, register indexes and timing tables.
package phfc_pkg;

  localparam logic [31:0] FAN_TICK_MS           = 32'd60000;
  localparam int          MAX_SHORTFALL         = 63;
  localparam logic [63:0] HEAT_ON_BASE_PERCENT  = 64'd200;
  localparam logic [63:0] HEAT_ON_ADJUST_MS     = 64'd60000;
  localparam logic [63:0] HEAT_OFF_BASE_PERCENT = 64'd200;
  localparam logic [63:0] HEAT_OFF_ADJUST_MS    = 64'd60000;

  localparam logic [31:0] FAULT_FAN_MULT      = 32'd10;
  localparam logic [31:0] FAULT_HEAT_ON_MULT  = 32'd30;
  localparam logic [31:0] FAULT_HEAT_OFF_MULT = 32'd10;

  localparam logic [31:0] FaultFanMs     = 32'(FAN_TICK_MS * FAULT_FAN_MULT);
  localparam logic [31:0] FaultHeatOnMs  = 32'(FAN_TICK_MS * FAULT_HEAT_ON_MULT);
  localparam logic [31:0] FaultHeatOffMs = 32'(FAN_TICK_MS * FAULT_HEAT_OFF_MULT);

  localparam int ShortW = $clog2(MAX_SHORTFALL + 1);

  localparam logic [63:0] QOne = 64'd1 << 32;

  // Status codes of a result item
  typedef enum logic [2:0] {
    ST_SENSOR_FAULT = 3'd0,
    ST_DEATH_TEMP   = 3'd1,
    ST_PROGRAM_OFF  = 3'd2,
    ST_OVER         = 3'd3,
    ST_IN_BAND      = 3'd4,
    ST_HEAT_OFF     = 3'd5,
    ST_HEAT_ON      = 3'd6,
    ST_IDLE         = 3'd7
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROGRAM     = 3'd0,
    REG_STARTER_MIN = 3'd1,
    REG_STARTER_MAX = 3'd2,
    REG_PROOF1_MIN  = 3'd3,
    REG_PROOF1_MAX  = 3'd4,
    REG_PROOF2_MIN  = 3'd5,
    REG_PROOF2_MAX  = 3'd6,
    REG_DEATH_MAX   = 3'd7
  } reg_idx_e;

  // Program selections
  typedef enum logic [1:0] {
    PROG_OFF     = 2'd0,
    PROG_STARTER = 2'd1,
    PROG_PROOF1  = 2'd2,
    PROG_PROOF2  = 2'd3
  } program_e;

  typedef logic [31:0] tab_t [MAX_SHORTFALL + 1];

  // (a*b + rnd) >> 32, saturating at 64 bits; elaboration only
  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, logic [63:0] rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + {64'd0, rnd};
    if (p[127:96] != 32'd0) return '1;
    return p[95:32];
  endfunction

  function automatic logic [63:0] pow10q(logic [63:0] x);
    logic [63:0] y;
    y = QOne;
    for (int i = 0; i < 10; i++) y = mulsh(y, x, 64'd0);
    return y;
  endfunction

  // Largest Q32 value whose tenth power stays at or below base/100
  function automatic logic [63:0] tenth_root(logic [63:0] base_pct);
    logic [63:0] b;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    b  = (base_pct << 32) / 64'd100;
    lo = QOne;
    hi = QOne << 1;
    for (int i = 0; i < 40; i++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (pow10q(mid) <= b) lo = mid;
        else hi = mid;
      end
    end
    return lo;
  endfunction

  // floor((2^64-1)/r), built bit by bit
  function automatic logic [63:0] recip_q(logic [63:0] r);
    logic [63:0]  q;
    logic [63:0]  t;
    logic [127:0] p;
    q = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      t = q | (64'd1 << i);
      p = {64'd0, t} * {64'd0, r};
      if (p <= {64'd0, {64{1'b1}}}) q = t;
    end
    return q;
  endfunction

  function automatic tab_t build_tab(logic [63:0] step, logic [63:0] adjust);
    tab_t        tab;
    logic [63:0] f;
    logic [63:0] e;
    f = QOne;
    for (int d = 0; d <= MAX_SHORTFALL; d++) begin
      e = mulsh(adjust, f, 64'd1 << 31);
      tab[d] = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
      f = mulsh(f, step, 64'd0);
    end
    return tab;
  endfunction

  localparam tab_t OnTab  = build_tab(tenth_root(HEAT_ON_BASE_PERCENT), HEAT_ON_ADJUST_MS);
  localparam tab_t OffTab = build_tab(recip_q(tenth_root(HEAT_OFF_BASE_PERCENT)),
                                      HEAT_OFF_ADJUST_MS);

endpackage

// File: design/proofing_heater_fan_controller.sv
// Top level: proofing box heater and fan controller, one tick per item.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | now_ms, sensor_valid, temp_c, humidity_pct
//  out     | source    | out_valid_o/out_stall_i | heater, fan, status, echoes
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  An item is held in the input register and moves into the result register
//  when the result register advances; one item per cycle is sustained while out_stall_i
//  is low, set by the single compare/add/table path between the two registers.
//  Reset puts the band registers at their defaults and clears the timers.
//  A stalled result holds; one more item waits in the input register, then
//  in_stall_o rises. Configuration writes are always ready.
`include "proofing_heater_fan_controller_assert.svh"

module proofing_heater_fan_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic        sensor_valid_i,
  input  logic signed [7:0] temp_c_i,
  input  logic [6:0]  humidity_pct_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        heater_drive_o,
  output logic        fan_drive_o,
  output logic [2:0]  status_o,
  output logic signed [7:0] temp_echo_o,
  output logic [6:0]  humidity_echo_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import phfc_pkg::*;

  // configuration registers
  logic [1:0]        program_q;
  logic signed [7:0] starter_min_q, starter_max_q, proof1_min_q, proof1_max_q;
  logic signed [7:0] proof2_min_q, proof2_max_q, death_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_q     <= PROG_OFF;
      starter_min_q <= 8'sd24;
      starter_max_q <= 8'sd27;
      proof1_min_q  <= 8'sd26;
      proof1_max_q  <= 8'sd29;
      proof2_min_q  <= 8'sd30;
      proof2_max_q  <= 8'sd35;
      death_max_q   <= 8'sd45;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PROGRAM:     program_q     <= cfg_data_i[1:0];
        REG_STARTER_MIN: starter_min_q <= cfg_data_i;
        REG_STARTER_MAX: starter_max_q <= cfg_data_i;
        REG_PROOF1_MIN:  proof1_min_q  <= cfg_data_i;
        REG_PROOF1_MAX:  proof1_max_q  <= cfg_data_i;
        REG_PROOF2_MIN:  proof2_min_q  <= cfg_data_i;
        REG_PROOF2_MAX:  proof2_max_q  <= cfg_data_i;
        REG_DEATH_MAX:   death_max_q   <= cfg_data_i;
        default:         death_max_q   <= death_max_q;
      endcase
    end
  end

  // handshake: result register drains, input register refills behind it
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  // input register
  logic [31:0]       now_q;
  logic              sv_q;
  logic signed [7:0] temp_q;
  logic [6:0]        hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      now_q  <= now_ms_i;
      sv_q   <= sensor_valid_i;
      temp_q <= temp_c_i;
      hum_q  <= humidity_pct_i;
    end
  end

  // controller state
  logic [31:0] prev_time_q, on_dl_q, off_dl_q, fan_dl_q;
  logic        heater_q, fan_q;
  logic [31:0] prev_time_d, on_dl_d, off_dl_d, fan_dl_d;
  logic        heater_d, fan_d;
  status_e     status_d;

  // band edges for the selected program
  logic signed [7:0] band_min, band_max;
  always_comb begin
    case (program_e'(program_q))
      PROG_STARTER: begin
        band_min = starter_min_q;
        band_max = starter_max_q;
      end
      PROG_PROOF1: begin
        band_min = proof1_min_q;
        band_max = proof1_max_q;
      end
      PROG_PROOF2: begin
        band_min = proof2_min_q;
        band_max = proof2_max_q;
      end
      default: begin
        band_min = starter_min_q;
        band_max = starter_max_q;
      end
    endcase
  end

  // shortfall below the band, saturated, and table reads
  logic signed [8:0]  shortfall;
  logic [ShortW-1:0]  sf_idx;
  logic [31:0]        on_ms, off_ms;

  assign shortfall = 9'(band_min) - 9'(temp_q);
  assign sf_idx    = (shortfall > $signed(9'(MAX_SHORTFALL))) ?
                     ShortW'(MAX_SHORTFALL) : shortfall[ShortW-1:0];
  assign on_ms     = OnTab[sf_idx];
  assign off_ms    = OffTab[sf_idx];

  // one tick of the control rule
  always_comb begin
    logic [31:0] on_dl;
    logic [31:0] off_dl;
    logic [31:0] fan_dl;
    logic        heater;
    logic        fan;

    on_dl  = (now_q < prev_time_q) ? 32'd0 : on_dl_q;
    off_dl = (now_q < prev_time_q) ? 32'd0 : off_dl_q;
    fan_dl = heater_q ? now_q + FAN_TICK_MS : fan_dl_q;
    heater = heater_q;
    fan    = fan_q;
    if (now_q < fan_dl) begin
      fan = 1'b1;
    end else if (fan_q) begin
      fan    = 1'b0;
      heater = 1'b0;
    end

    if (!sv_q || (temp_q > death_max_q)) begin
      // fault backoff
      heater   = 1'b0;
      fan_dl   = now_q + FaultFanMs;
      on_dl    = now_q + FaultHeatOnMs;
      off_dl   = now_q + FaultHeatOffMs;
      status_d = !sv_q ? ST_SENSOR_FAULT : ST_DEATH_TEMP;
    end else if (program_e'(program_q) == PROG_OFF) begin
      heater   = 1'b0;
      status_d = ST_PROGRAM_OFF;
    end else if (band_max <= temp_q) begin
      heater   = 1'b0;
      fan_dl   = now_q + FAN_TICK_MS;
      status_d = ST_OVER;
    end else if (band_min <= temp_q) begin
      heater   = 1'b0;
      status_d = ST_IN_BAND;
    end else if (off_dl <= now_q && heater) begin
      heater   = 1'b0;
      on_dl    = now_q + off_ms;
      off_dl   = now_q + off_ms + on_ms;
      status_d = ST_HEAT_OFF;
    end else if (on_dl <= now_q && !heater) begin
      fan      = 1'b1;
      heater   = 1'b1;
      off_dl   = now_q + on_ms;
      on_dl    = now_q + on_ms + off_ms;
      status_d = ST_HEAT_ON;
    end else begin
      status_d = ST_IDLE;
    end

    prev_time_d = now_q;
    on_dl_d     = on_dl;
    off_dl_d    = off_dl;
    fan_dl_d    = fan_dl;
    heater_d    = heater;
    fan_d       = fan;
  end

  // state commits when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= 32'd0;
      on_dl_q     <= 32'd0;
      off_dl_q    <= 32'd0;
      fan_dl_q    <= 32'd0;
      heater_q    <= 1'b0;
      fan_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        prev_time_q <= prev_time_d;
        on_dl_q     <= on_dl_d;
        off_dl_q    <= off_dl_d;
        fan_dl_q    <= fan_dl_d;
        heater_q    <= heater_d;
        fan_q       <= fan_d;
      end
    end
  end

  // result register
  logic [2:0]        status_q;
  logic signed [7:0] temp_echo_q;
  logic [6:0]        hum_echo_q;

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      status_q    <= status_d;
      temp_echo_q <= sv_q ? temp_q : 8'sd0;
      hum_echo_q  <= sv_q ? hum_q : 7'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heater_drive_o  = heater_q;
  assign fan_drive_o     = fan_q;
  assign status_o        = status_q;
  assign temp_echo_o     = temp_echo_q;
  assign humidity_echo_o = hum_echo_q;

  // checks
  `PHFC_ASSERT_NOW(a_fault_heater_off,
    out_valid_o && (status_o == ST_SENSOR_FAULT || status_o == ST_DEATH_TEMP),
    !heater_drive_o)
  `PHFC_ASSERT_NOW(a_fault_echo_zero,
    out_valid_o && status_o == ST_SENSOR_FAULT,
    temp_echo_o == 8'sd0 && humidity_echo_o == 7'd0)
  `PHFC_ASSERT_NOW(a_stall_only_when_full, in_stall_o, s1_valid_q && out_valid_q)
  `PHFC_ASSERT_NEXT(a_pending_moves_up,
    s1_valid_q && !out_stall_i,
    out_valid_o)

endmodule

// File: verif/tb_proofing_heater_fan_controller.sv
// Testbench for the proofing box heater and fan controller: directed and random ticks checked against a predictor.
module tb_proofing_heater_fan_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import phfc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 113;
  localparam int PRINT_LIMIT  = 100;

  // One tick as offered on the input channel
  typedef struct packed {
    logic [31:0]       now;
    logic              ok;
    logic signed [7:0] temp;
    logic [6:0]        hum;
  } tick_t;

  // Heater, fan, status and echoes a tick should produce
  typedef struct packed {
    logic              heater;
    logic              fan;
    status_e           status;
    logic signed [7:0] temp;
    logic [6:0]        hum;
  } drive_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [31:0]       now_ms_i       = '0;
  logic              sensor_valid_i = 1'b0;
  logic signed [7:0] temp_c_i       = '0;
  logic [6:0]        humidity_pct_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              heater_drive_o;
  logic              fan_drive_o;
  logic [2:0]        status_o;
  logic signed [7:0] temp_echo_o;
  logic [6:0]        humidity_echo_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i    = '0;
  logic [7:0]        cfg_data_i     = '0;

  // Predictor state: configuration copy, timers and drive states
  logic [7:0]  reg_file [8];
  logic [31:0] on_ms    [0:MAX_SHORTFALL];
  logic [31:0] off_ms   [0:MAX_SHORTFALL];
  logic [31:0] last_ms  = '0;
  logic [31:0] on_due   = '0;
  logic [31:0] off_due  = '0;
  logic [31:0] fan_due  = '0;
  logic        heater_on = 1'b0;
  logic        fan_on    = 1'b0;

  tick_t  tick_q[$];
  drive_t drive_q[$];

  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap_max  = 0;
  int          out_gap_max = 0;
  int          in_gap      = 0;
  int          out_wait    = 0;
  int          hold_gen    = 0;
  int          hold_len    = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          err_cnt     = 0;
  int          cycle_cnt   = 0;
  logic [31:0] sim_ms      = '0;

  proofing_heater_fan_controller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .sensor_valid_i (sensor_valid_i),
    .temp_c_i       (temp_c_i),
    .humidity_pct_i (humidity_pct_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .heater_drive_o (heater_drive_o),
    .fan_drive_o    (fan_drive_o),
    .status_o       (status_o),
    .temp_echo_o    (temp_echo_o),
    .humidity_echo_o(humidity_echo_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  // Q32 multiply with rounding term, truncated, saturating at 64 bits
  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] rnd);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b} + {64'd0, rnd};
    return (wide[127:96] != '0) ? '1 : wide[95:32];
  endfunction

  // Largest Q32 step whose tenth power stays at or below pct/100
  function automatic logic [63:0] q32_tenth_root(input logic [63:0] pct);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] acc;
    target = (pct << 32) / 64'd100;
    lo     = 64'd1 << 32;
    hi     = 64'd1 << 33;
    while (hi - lo > 64'd1) begin
      mid = lo + (hi - lo) / 64'd2;
      acc = 64'd1 << 32;
      for (int k = 0; k < 10; k++) acc = q32_mul(acc, mid, 64'd0);
      if (acc <= target) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Signed band edge of a program, from the configuration copy
  function automatic int band_edge(input program_e prog, input logic upper);
    int idx;
    case (prog)
      PROG_PROOF1: idx = upper ? REG_PROOF1_MAX : REG_PROOF1_MIN;
      PROG_PROOF2: idx = upper ? REG_PROOF2_MAX : REG_PROOF2_MIN;
      default:     idx = upper ? REG_STARTER_MAX : REG_STARTER_MIN;
    endcase
    return $signed(reg_file[idx]);
  endfunction

  // Temperature register value, extremes weighted up
  function automatic logic [7:0] draw_band_value();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 15) v = -40;
    else if (pick < 30) v = 80;
    else v = int'($urandom_range(0, 120)) - 40;
    return v[7:0];
  endfunction

  // Advance the timers by one tick and work out the drives it yields
  task automatic next_drive(input tick_t tk, output drive_t res);
    int       t;
    int       lo_edge;
    int       hi_edge;
    int       short_deg;
    program_e prog;
    status_e  st;
    prog = program_e'(reg_file[REG_PROGRAM][1:0]);
    t    = $signed(tk.temp);
    // time going backwards drops the heat deadlines
    if (tk.now < last_ms) begin
      on_due  = '0;
      off_due = '0;
    end
    last_ms = tk.now;
    if (heater_on) fan_due = tk.now + FAN_TICK_MS;
    if (tk.now < fan_due) fan_on = 1'b1;
    else if (fan_on) begin
      fan_on    = 1'b0;
      heater_on = 1'b0;
    end
    if (!tk.ok || t > $signed(reg_file[REG_DEATH_MAX])) begin
      // sensor fault or death temperature: heater off, deadlines pushed out
      heater_on = 1'b0;
      fan_due   = tk.now + FAN_TICK_MS * FAULT_FAN_MULT;
      on_due    = tk.now + FAN_TICK_MS * FAULT_HEAT_ON_MULT;
      off_due   = tk.now + FAN_TICK_MS * FAULT_HEAT_OFF_MULT;
      st        = tk.ok ? ST_DEATH_TEMP : ST_SENSOR_FAULT;
    end else if (prog == PROG_OFF) begin
      heater_on = 1'b0;
      st        = ST_PROGRAM_OFF;
    end else begin
      lo_edge = band_edge(prog, 1'b0);
      hi_edge = band_edge(prog, 1'b1);
      if (hi_edge <= t) begin
        heater_on = 1'b0;
        fan_due   = tk.now + FAN_TICK_MS;
        st        = ST_OVER;
      end else if (lo_edge <= t) begin
        heater_on = 1'b0;
        st        = ST_IN_BAND;
      end else begin
        short_deg = lo_edge - t;
        if (short_deg > MAX_SHORTFALL) short_deg = MAX_SHORTFALL;
        if (off_due <= tk.now && heater_on) begin
          heater_on = 1'b0;
          on_due    = tk.now + off_ms[short_deg];
          off_due   = on_due + on_ms[short_deg];
          st        = ST_HEAT_OFF;
        end else if (on_due <= tk.now && !heater_on) begin
          fan_on    = 1'b1;
          heater_on = 1'b1;
          off_due   = tk.now + on_ms[short_deg];
          on_due    = off_due + off_ms[short_deg];
          st        = ST_HEAT_ON;
        end else begin
          st = ST_IDLE;
        end
      end
    end
    res.heater = heater_on;
    res.fan    = fan_on;
    res.status = st;
    res.temp   = tk.ok ? tk.temp : '0;
    res.hum    = tk.ok ? tk.hum : '0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    // keep the log readable when the block is badly off
    if (err_cnt < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_tick(input logic [31:0] ms, input logic ok, input int t, input int h);
    tick_t tk;
    tk.now  = ms;
    tk.ok   = ok;
    tk.temp = t[7:0];
    tk.hum  = h[6:0];
    tick_q.push_back(tk);
  endtask

  // Ticks with mostly rising time and temperatures around the active band
  task automatic queue_random(input int count);
    int       pick;
    int       lo_edge;
    int       hi_edge;
    int       tv;
    program_e prog;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) sim_ms += $urandom_range(0, 40000);
      else if (pick < 85) sim_ms += $urandom_range(40000, 800000);
      else if (pick < 90) sim_ms -= $urandom_range(1, 300000);
      else if (pick < 95) sim_ms = $urandom();
      else sim_ms += $urandom_range(0, 3);
      prog    = program_e'(reg_file[REG_PROGRAM][1:0]);
      lo_edge = band_edge(prog, 1'b0);
      hi_edge = band_edge(prog, 1'b1);
      pick    = $urandom_range(0, 99);
      if (pick < 55) tv = lo_edge - int'($urandom_range(0, 12));
      else if (pick < 70) tv = ((pick < 62) ? lo_edge : hi_edge) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 80) tv = lo_edge - int'($urandom_range(0, 120));
      else tv = int'($urandom_range(0, 120)) - 40;
      if (tv < -40) tv = -40;
      if (tv > 80) tv = 80;
      queue_tick(sim_ms, $urandom_range(0, 99) < 94, tv, $urandom_range(0, 100));
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_file[idx] = (idx == REG_PROGRAM) ? {6'd0, val[1:0]} : val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued item went in and every result came out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || drive_q.size() != 0);
  endtask

  // Input driver: holds an item until taken, then idles for its drawn gap
  always @(negedge clk_i) begin
    tick_t nxt;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        nxt             = tick_q.pop_front();
        in_valid_i     <= 1'b1;
        now_ms_i       <= nxt.now;
        sensor_valid_i <= nxt.ok;
        temp_c_i       <= nxt.temp;
        humidity_pct_i <= nxt.hum;
        in_gap          = $urandom_range(0, in_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stall per item, plus a long hold on request
  always @(negedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = hold_len;
    end
    if (out_fire) out_wait = $urandom_range(0, out_gap_max);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each accepted tick, check each accepted result
  always @(posedge clk_i) begin
    tick_t  tk;
    drive_t want;
    if (rst_ni) begin
      in_fire  <= in_valid_i && !in_stall_o;
      out_fire <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        tk.now  = now_ms_i;
        tk.ok   = sensor_valid_i;
        tk.temp = temp_c_i;
        tk.hum  = humidity_pct_i;
        next_drive(tk, want);
        drive_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          flag_mismatch("result with nothing pending, status", status_o, '0);
        end else begin
          want = drive_q.pop_front();
          if (heater_drive_o !== want.heater)
            flag_mismatch("heater_drive", heater_drive_o, want.heater);
          if (fan_drive_o !== want.fan) flag_mismatch("fan_drive", fan_drive_o, want.fan);
          if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
          if (temp_echo_o !== want.temp) flag_mismatch("temp_echo", temp_echo_o, want.temp);
          if (humidity_echo_o !== want.hum)
            flag_mismatch("humidity_echo", humidity_echo_o, want.hum);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [63:0] up_step;
    logic [63:0] down_step;
    logic [63:0] up_f;
    logic [63:0] down_f;
    logic [63:0] scaled;
    logic [7:0]  lo_v;
    logic [7:0]  hi_v;
    logic [1:0]  pv;
    int          hi_i;

    // heat on/off duration tables, indexed by whole-degree shortfall
    up_step   = q32_tenth_root(HEAT_ON_BASE_PERCENT);
    down_step = 64'hFFFF_FFFF_FFFF_FFFF / q32_tenth_root(HEAT_OFF_BASE_PERCENT);
    up_f      = 64'd1 << 32;
    down_f    = 64'd1 << 32;
    for (int d = 0; d <= MAX_SHORTFALL; d++) begin
      scaled    = q32_mul(HEAT_ON_ADJUST_MS, up_f, 64'd1 << 31);
      on_ms[d]  = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      scaled    = q32_mul(HEAT_OFF_ADJUST_MS, down_f, 64'd1 << 31);
      off_ms[d] = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      up_f      = q32_mul(up_f, up_step, 64'd0);
      down_f    = q32_mul(down_f, down_step, 64'd0);
    end

    // configuration after reset
    reg_file[REG_PROGRAM]     = PROG_OFF;
    reg_file[REG_STARTER_MIN] = 8'd24;
    reg_file[REG_STARTER_MAX] = 8'd27;
    reg_file[REG_PROOF1_MIN]  = 8'd26;
    reg_file[REG_PROOF1_MAX]  = 8'd29;
    reg_file[REG_PROOF2_MIN]  = 8'd30;
    reg_file[REG_PROOF2_MAX]  = 8'd35;
    reg_file[REG_DEATH_MAX]   = 8'd45;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // program off: faults and death temperature still take precedence
    in_gap_max  = 2;
    out_gap_max = 2;
    queue_tick(32'd0, 1'b1, 20, 50);
    queue_tick(32'd1000, 1'b0, -1, 100);
    queue_tick(32'd2000, 1'b1, 80, 0);
    queue_tick(32'd3000, 1'b1, -40, 63);
    wait_drained();

    // starter band; upper data bits of the program write are dropped
    write_reg(REG_PROGRAM, 8'hFD);
    queue_tick(32'd500, 1'b1, 27, 64);          // time steps back, over the band
    queue_tick(32'd600, 1'b1, 25, 10);          // in band
    queue_tick(32'd700, 1'b1, 20, 40);          // below: heater on
    queue_tick(32'd10000, 1'b1, 20, 40);        // waiting
    queue_tick(32'd200000, 1'b1, 20, 40);       // on time over: heater off
    queue_tick(32'd300000, 1'b1, 20, 40);       // off time over: heater on
    queue_tick(32'd1000000, 1'b1, -40, 40);     // shortfall saturates
    queue_tick(32'hFFFF_FF00, 1'b1, -40, 40);   // deadlines wrap past 2^32
    queue_tick(32'hFFFF_FFFF, 1'b1, -40, 40);   // fan deadline wrapped below now
    queue_tick(32'h0000_0100, 1'b1, 23, 40);    // time wraps back to small
    queue_tick(32'h8000_0000, 1'b1, 26, 40);
    wait_drained();

    // widest band and highest death limit
    write_reg(REG_PROGRAM, PROG_PROOF1);
    write_reg(REG_PROOF1_MIN, 8'hD8);           // -40
    write_reg(REG_PROOF1_MAX, 8'd80);
    write_reg(REG_DEATH_MAX, 8'd80);
    queue_tick(32'h8000_1000, 1'b1, -40, 0);
    queue_tick(32'h8000_2000, 1'b1, 80, 100);
    wait_drained();

    // crossed band edges
    write_reg(REG_PROGRAM, PROG_PROOF2);
    write_reg(REG_PROOF2_MIN, 8'd80);
    write_reg(REG_PROOF2_MAX, 8'hE2);           // -30
    queue_tick(32'h8000_3000, 1'b1, -35, 20);
    queue_tick(32'h8000_4000, 1'b1, -30, 20);
    queue_tick(32'h8000_5000, 1'b0, 80, 0);
    wait_drained();

    // lowest death limit: only -40 escapes it
    write_reg(REG_DEATH_MAX, 8'hD8);
    queue_tick(32'h8000_6000, 1'b1, -35, 20);
    queue_tick(32'h8000_7000, 1'b1, -40, 20);
    sim_ms = 32'h8010_0000;

    // random phases, each with fresh configuration and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      for (int r = REG_STARTER_MIN; r < REG_DEATH_MAX; r += 2) begin
        lo_v = draw_band_value();
        if ($urandom_range(0, 9) < 7) begin
          hi_i = $signed(lo_v) + int'($urandom_range(1, 8));
          if (hi_i > 80) hi_i = 80;
          hi_v = hi_i[7:0];
        end else begin
          hi_v = draw_band_value();
        end
        write_reg(reg_idx_e'(r), lo_v);
        write_reg(reg_idx_e'(r + 1), hi_v);
      end
      write_reg(REG_DEATH_MAX, ($urandom_range(0, 9) < 7) ? 8'($urandom_range(30, 80))
                                                          : draw_band_value());
      pv = (ph == 6) ? PROG_OFF : 2'($urandom_range(1, 3));
      write_reg(REG_PROGRAM, {6'($urandom()), pv});

      case (ph % 3)
        0: begin
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        1: begin
          in_gap_max  = 15;
          out_gap_max = 15;
        end
        default: begin
          in_gap_max  = (ph % 2 == 0) ? 0 : 15;
          out_gap_max = (ph % 2 == 0) ? 15 : 0;
        end
      endcase
      // long receiver hold with back-to-back items so the block backs up
      if (ph == 4) begin
        in_gap_max = 0;
        hold_len   = 400;
        hold_gen++;
      end
      queue_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
